// ===== design/signed_int_to_decimal_ascii_macros.svh =====
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH

// Same-cycle implication, sampled on clk_i and idle while rst_ni is low.
`define SIDA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and idle while rst_ni is low.
`define SIDA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/sida_pkg.sv =====
`default_nettype none

package sida_pkg;

  localparam int unsigned PcW       = 3;
  localparam int unsigned OpW       = 3;
  localparam int unsigned ValW      = 32;
  localparam int unsigned NumDigits = 10;
  localparam int unsigned DigW      = 4;
  localparam int unsigned BcdW      = NumDigits * 4;
  localparam int unsigned IterW     = 5;

  localparam logic [OpW-1:0] OpLoad   = 3'd0;
  localparam logic [OpW-1:0] OpDabble = 3'd1;
  localparam logic [OpW-1:0] OpSkip   = 3'd2;
  localparam logic [OpW-1:0] OpSign   = 3'd3;
  localparam logic [OpW-1:0] OpEmit   = 3'd4;

  localparam logic [PcW-1:0] PcLoad   = 3'd0;
  localparam logic [PcW-1:0] PcDabble = 3'd1;
  localparam logic [PcW-1:0] PcSkip   = 3'd2;
  localparam logic [PcW-1:0] PcSign   = 3'd3;
  localparam logic [PcW-1:0] PcEmit   = 3'd4;

  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChZero  = 8'h30;

  typedef struct packed {
    logic [OpW-1:0] op;
    logic [PcW-1:0] loop_pc;
    logic [PcW-1:0] exit_pc;
  } ctrl_word_t;

  // Each step either holds, loops to loop_pc, or falls out to exit_pc.
  function automatic ctrl_word_t ucode_rom(input logic [PcW-1:0] pc);
    ctrl_word_t w;
    case (pc)
      PcLoad:   w = '{op: OpLoad,   loop_pc: PcLoad,   exit_pc: PcDabble};
      PcDabble: w = '{op: OpDabble, loop_pc: PcDabble, exit_pc: PcSkip};
      PcSkip:   w = '{op: OpSkip,   loop_pc: PcSkip,   exit_pc: PcSign};
      PcSign:   w = '{op: OpSign,   loop_pc: PcSign,   exit_pc: PcEmit};
      PcEmit:   w = '{op: OpEmit,   loop_pc: PcEmit,   exit_pc: PcLoad};
      default:  w = '{op: OpLoad,   loop_pc: PcLoad,   exit_pc: PcLoad};
    endcase
    return w;
  endfunction

  // Adds three to every BCD digit of five or more ahead of the shift.
  function automatic logic [BcdW-1:0] bcd_adjust(input logic [BcdW-1:0] b);
    logic [BcdW-1:0] r;
    r = b;
    for (int k = 0; k < NumDigits; k++) begin
      if (b[k*4 +: 4] >= 4'd5) begin
        r[k*4 +: 4] = b[k*4 +: 4] + 4'd3;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/signed_int_to_decimal_ascii.sv =====
// Each request runs one load step, 32 shift-and-add-3 steps, and a ten-digit walk that
// skips leading zeros, sends the sign and sends the digits one per cycle while the
// output is not stalled. A new request is taken only once the last character has been
// loaded into the output register. Output stalls hold the sign or digit step that is
// waiting to send. Reset is asynchronous, active low, and empties the output register.
`default_nettype none

module signed_int_to_decimal_ascii (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic signed [31:0] value_i,
  input  wire logic               in_valid_i,
  output      logic               in_stall_o,
  output      logic [7:0]         char_code_o,
  output      logic               last_o,
  output      logic               out_valid_o,
  input  wire logic               out_stall_i
);

  logic [sida_pkg::PcW-1:0]   pc_q, pc_d;
  sida_pkg::ctrl_word_t       cw;
  logic                       hold, again, out_free;

  logic [sida_pkg::ValW-1:0]  mag_q, mag_d;
  logic [sida_pkg::BcdW-1:0]  bcd_q, bcd_d;
  logic [sida_pkg::IterW-1:0] iter_q, iter_d;
  logic [sida_pkg::DigW-1:0]  dcnt_q, dcnt_d;
  logic                       neg_q, neg_d;
  logic                       out_valid_q, out_valid_d;
  logic [7:0]                 out_char_q, out_char_d;
  logic                       out_last_q, out_last_d;

  logic [sida_pkg::BcdW+sida_pkg::ValW-1:0] dab_shift;
  logic [3:0]                               top_dig;

  assign cw        = sida_pkg::ucode_rom(pc_q);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign dab_shift = {sida_pkg::bcd_adjust(bcd_q), mag_q} << 1;
  assign top_dig   = bcd_q[sida_pkg::BcdW-1 -: 4];

  always_comb begin
    hold        = 1'b0;
    again       = 1'b0;
    mag_d       = mag_q;
    bcd_d       = bcd_q;
    iter_d      = iter_q;
    dcnt_d      = dcnt_q;
    neg_d       = neg_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    case (cw.op)
      sida_pkg::OpLoad: begin
        hold = !in_valid_i;
        if (in_valid_i) begin
          neg_d  = value_i[31];
          mag_d  = value_i[31] ? (32'd0 - $unsigned(value_i)) : $unsigned(value_i);
          bcd_d  = '0;
          iter_d = '1;
          dcnt_d = sida_pkg::DigW'(sida_pkg::NumDigits - 1);
        end
      end
      sida_pkg::OpDabble: begin
        bcd_d  = dab_shift[sida_pkg::BcdW+sida_pkg::ValW-1 -: sida_pkg::BcdW];
        mag_d  = dab_shift[sida_pkg::ValW-1:0];
        iter_d = iter_q - 1'b1;
        again  = (iter_q != '0);
      end
      sida_pkg::OpSkip: begin
        if (top_dig == 4'd0 && dcnt_q != '0) begin
          again  = 1'b1;
          bcd_d  = bcd_q << 4;
          dcnt_d = dcnt_q - 1'b1;
        end
      end
      sida_pkg::OpSign: begin
        if (neg_q) begin
          hold = !out_free;
          if (out_free) begin
            out_valid_d = 1'b1;
            out_char_d  = sida_pkg::ChMinus;
            out_last_d  = 1'b0;
          end
        end
      end
      sida_pkg::OpEmit: begin
        hold = !out_free;
        if (out_free) begin
          out_valid_d = 1'b1;
          out_char_d  = sida_pkg::ChZero | {4'h0, top_dig};
          out_last_d  = (dcnt_q == '0);
          bcd_d       = bcd_q << 4;
          dcnt_d      = dcnt_q - 1'b1;
          again       = (dcnt_q != '0);
        end
      end
      default: begin
        hold = 1'b0;
      end
    endcase
    pc_d = hold ? pc_q : (again ? cw.loop_pc : cw.exit_pc);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= sida_pkg::PcLoad;
      out_valid_q <= 1'b0;
    end else begin
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q      <= mag_d;
    bcd_q      <= bcd_d;
    iter_q     <= iter_d;
    dcnt_q     <= dcnt_d;
    neg_q      <= neg_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  assign in_stall_o  = (pc_q != sida_pkg::PcLoad);
  assign out_valid_o = out_valid_q;
  assign char_code_o = out_char_q;
  assign last_o      = out_last_q;

endmodule

`default_nettype wire

// ===== design/sida_checker.sv =====
`default_nettype none
`include "signed_int_to_decimal_ascii_macros.svh"

module sida_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic [7:0] char_code_o,
  input wire logic       last_o,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i
);

  `SIDA_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
    out_valid_o && $stable(char_code_o) && $stable(last_o),
    "Stalled output request changed.")
  `SIDA_ASSERT_NEXT(a_busy_after_req, in_valid_i && !in_stall_o, in_stall_o,
    "A second request was taken during a conversion.")
  `SIDA_ASSERT_NOW(a_char_set, out_valid_o,
    char_code_o == 8'h2D || (char_code_o >= 8'h30 && char_code_o <= 8'h39),
    "Output character is neither a digit nor a minus sign.")
  `SIDA_ASSERT_NOW(a_minus_not_last, out_valid_o && char_code_o == 8'h2D, !last_o,
    "A minus sign was marked as the last character.")

endmodule

bind signed_int_to_decimal_ascii sida_checker u_sida_checker (.*);

`default_nettype wire

// ===== verif/signed_int_to_decimal_ascii_checker.sv =====
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic signed [31:0] value_i,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic [7:0]        char_code_i,
  input  logic              last_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  output int unsigned       fail_count_o,
  output int unsigned       pending_o
);

  localparam logic [31:0] DecBase    = 32'd10;
  localparam logic [31:0] TopPower   = 32'd1_000_000_000;
  localparam int unsigned ReportMax  = 10;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } ascii_char_t;

  ascii_char_t expected_chars[$];

  // Queues the characters of one request: an optional minus sign, then the
  // digits from the largest power of ten down with leading zeros dropped.
  function automatic void predict_decimal_text(input logic [31:0] raw);
    logic [31:0] mag;
    logic [31:0] scale;
    logic [31:0] digit;
    bit          started;
    mag     = raw;
    started = 1'b0;
    if (raw[31]) begin
      expected_chars.push_back('{code: sida_pkg::ChMinus, last: 1'b0});
      mag = 32'd0 - raw;
    end
    if (mag == 32'd0) begin
      expected_chars.push_back('{code: sida_pkg::ChZero, last: 1'b1});
      return;
    end
    scale = TopPower;
    for (int i = 0; i < sida_pkg::NumDigits; i++) begin
      digit = mag / scale;
      mag   = mag % scale;
      if (digit != 32'd0) begin
        started = 1'b1;
      end
      if (started) begin
        expected_chars.push_back('{code: sida_pkg::ChZero + digit[7:0],
                                   last: (i == sida_pkg::NumDigits - 1)});
      end
      scale = scale / DecBase;
    end
  endfunction

  always @(posedge clk_i) begin : monitor
    ascii_char_t want;
    if (rst_ni && out_valid_i && !out_stall_i) begin
      if (expected_chars.size() == 0) begin
        fail_count_o++;
        if (fail_count_o <= ReportMax) begin
          $display("%0t: unexpected character %h (last %b) with nothing pending",
                   $realtime, char_code_i, last_i);
        end
      end else begin
        want = expected_chars.pop_front();
        if (char_code_i !== want.code || last_i !== want.last) begin
          fail_count_o++;
          if (fail_count_o <= ReportMax) begin
            $display("%0t: mismatch: expected char %h last %b, got char %h last %b",
                     $realtime, want.code, want.last, char_code_i, last_i);
          end
        end
      end
    end
    if (rst_ni && in_valid_i && !in_stall_i) begin
      predict_decimal_text(value_i);
    end
    pending_o = expected_chars.size();
  end

endmodule

// ===== verif/signed_int_to_decimal_ascii_tb.sv =====
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_tb;

  localparam int unsigned RandomItems   = 450;
  localparam int unsigned QuietFirst    = 200;
  localparam int unsigned QuietLast     = 300;
  localparam int unsigned PauseItem     = 350;
  localparam int unsigned IdlePercent   = 11;
  localparam int unsigned DrainCycles   = 60;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned DirectedCount = 20;

  localparam logic [31:0] Directed [DirectedCount] = '{
    32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'hFFFF_FFF7, 32'd10, 32'hFFFF_FFF6,
    32'd100, 32'd101, 32'd99, 32'd1_000_000_000, 32'd999_999_999,
    32'hC465_3600, 32'hC465_3601, 32'h7FFF_FFFF, 32'h8000_0001, 32'h8000_0000,
    32'h5555_5555, 32'hAAAA_AAAA, 32'd1_234_567_890
  };

  logic               clk_i;
  logic               rst_ni      = 1'b0;
  logic signed [31:0] value_i     = '0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  logic [7:0]         char_code_o;
  logic               last_o;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               idle_off    = 1'b0;
  logic               in_accept_q = 1'b0;
  int unsigned        fail_count;
  int unsigned        pending_chars;

  signed_int_to_decimal_ascii dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .value_i     (value_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .char_code_o (char_code_o),
    .last_o      (last_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i)
  );

  signed_int_to_decimal_ascii_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .value_i      (value_i),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .char_code_i  (char_code_o),
    .last_i       (last_o),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .fail_count_o (fail_count),
    .pending_o    (pending_chars)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  always @(posedge clk_i) begin
    in_accept_q <= rst_ni && in_valid_i && !in_stall_o;
  end

  always @(negedge clk_i) begin
    out_stall_i <= !idle_off && ($urandom_range(99) < IdlePercent);
  end

  function automatic longint power_of_ten(input int unsigned exponent);
    longint p;
    p = 1;
    for (int k = 0; k < exponent; k++) begin
      p = p * 10;
    end
    return p;
  endfunction

  // Mostly numbers of a random digit count, some around powers of ten,
  // the rest raw 32-bit patterns.
  function automatic logic [31:0] random_value();
    int unsigned pick;
    int unsigned ndig;
    longint      lo;
    longint      hi;
    longint      mag;
    pick = $urandom_range(99);
    if (pick < 25) begin
      return $urandom();
    end
    ndig = $urandom_range(1, 10);
    if (pick < 40) begin
      mag = power_of_ten(ndig - 1) + $urandom_range(2) - 1;
    end else begin
      lo  = (ndig == 1) ? 0 : power_of_ten(ndig - 1);
      hi  = (ndig == 10) ? 64'd2147483647 : power_of_ten(ndig) - 1;
      mag = lo + (longint'($urandom()) % (hi - lo + 1));
    end
    if ($urandom_range(1) == 1) begin
      mag = -mag;
    end
    return mag[31:0];
  endfunction

  task automatic send_value(input logic [31:0] v);
    while (!idle_off && ($urandom_range(99) < IdlePercent)) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= v;
    do @(negedge clk_i); while (!in_accept_q);
  endtask

  task automatic drain_pending();
    in_valid_i <= 1'b0;
    while (pending_chars != 0) begin
      @(negedge clk_i);
    end
  endtask

  initial begin : stimulus
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    foreach (Directed[i]) begin
      send_value(Directed[i]);
    end
    drain_pending();
    for (int n = 0; n < RandomItems; n++) begin
      idle_off <= (n >= QuietFirst) && (n < QuietLast);
      if (n == PauseItem) begin
        drain_pending();
      end
      send_value(random_value());
    end
    drain_pending();
    repeat (DrainCycles) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin : watchdog
    int unsigned quiet_run;
    quiet_run = 0;
    while (quiet_run < WatchdogLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_run = 0;
      end else begin
        quiet_run++;
      end
    end
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/sida_pkg.sv
design/signed_int_to_decimal_ascii.sv
design/sida_checker.sv
verif/signed_int_to_decimal_ascii_checker.sv
verif/signed_int_to_decimal_ascii_tb.sv
